@@ rtl/htcr_pkg.sv @@
// Package for the coalesced hash table: operation and status codes, field widths, empty value.
// No dependencies.
`default_nettype none
package htcr_pkg;
    localparam int KEY_W   = 48;
    localparam int VALUE_W = 32;
    localparam int OUT_W   = 6;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_DELETE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

    localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;
endpackage
`default_nettype wire

@@ rtl/htcr_mem.sv @@
// Slot memory of the hash table: key, value, link valid flag and link, one entry
// per slot, one write and one registered read per cycle. Depends on nothing else.
`default_nettype none
module htcr_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 82
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/hash_table_chaining_with_replacement.sv @@
// Coalesced hash table with replacement; the slot memory sits in htcr_mem.
// An insert into a free home slot writes it directly, and a key found in its home slot is acted
// on there; otherwise the block reads slot after slot, probing for a free slot or walking a chain.
// The block works on one item at a time: a new item is accepted only in the idle state.
// After reset a clearing pass writes an empty entry to every slot; no item is taken before it ends.
`default_nettype none
module hash_table_chaining_with_replacement #(
    parameter int TABLE_SIZE = 64,
    parameter int KEY_BYTES  = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [47:0] key,
    input  wire logic signed [31:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [5:0]       slot,
    output logic [5:0]       probes,
    output logic signed [31:0] found_value
);
    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = AW + 1;
    localparam int EW = htcr_pkg::KEY_W + htcr_pkg::VALUE_W + 1 + AW;
    localparam int KM = 8 * KEY_BYTES;
    // The byte sum never exceeds 1530, so this reciprocal gives the exact quotient.
    localparam int HSH = 22;
    localparam longint HMUL = (longint'(1) << HSH) / TABLE_SIZE + 1;

    typedef struct packed {
        logic [47:0] k;
        logic [31:0] v;
        logic        lv;
        logic [AW-1:0] ln;
    } entry_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_HOME, S_PROBER, S_PROBE, S_TAILR, S_TAIL,
        S_PREDR, S_PRED, S_WMOVE, S_WHOME, S_WNEW, S_LOCR, S_LOC, S_ACT,
        S_DNEXTR, S_DNEXT, S_DPREDR, S_DPRED, S_DCLR, S_OUT
    } state_t;

    function automatic logic [AW-1:0] home_of(input logic [47:0] k);
        logic [10:0] s;
        logic [33:0] prod;
        logic [10:0] q;
        logic [10:0] r;
        s = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            s = s + 11'(k[8*b +: 8]);
        end
        prod = 34'(s) * 34'(HMUL);
        q = prod[HSH +: 11];
        r = s - q * 11'(TABLE_SIZE);
        return AW'(r);
    endfunction

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
        return (a == AW'(TABLE_SIZE - 1)) ? '0 : a + AW'(1);
    endfunction

    state_t state_reg;
    logic [1:0]  op_reg;
    logic [47:0] key_reg;
    logic [31:0] val_reg;
    logic [AW-1:0] h_reg, f_reg, c_reg, at_reg, oh_reg;
    logic [CW-1:0] n_reg;
    entry_t hent_reg, ment_reg;
    logic [1:0] st_reg;
    logic [5:0] slot_reg, pr_reg;
    logic [31:0] fv_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    entry_t wd, rd;
    logic [EW-1:0] rd_raw;

    htcr_mem #(.DEPTH(TABLE_SIZE), .AW(AW), .W(EW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(EW'(wd)), .raddr(raddr),
        .rdata(rd_raw)
    );
    assign rd = entry_t'(rd_raw);

    entry_t empty_e, new_e;
    assign empty_e = '{k: '0, v: htcr_pkg::EMPTY_VALUE, lv: 1'b0, ln: '0};
    assign new_e = '{k: key_reg, v: val_reg, lv: 1'b0, ln: '0};

    logic [47:0] kin;
    assign kin = (KM >= 48) ? key : (key & ((48'd1 << KM) - 48'd1));

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status = st_reg;
    assign slot = slot_reg;
    assign probes = pr_reg;
    assign found_value = fv_reg;

    // Memory port: read address and write are decoded from the state.
    always_comb
    begin
        we = 1'b0;
        waddr = c_reg;
        wd = empty_e;
        raddr = c_reg;
        case (state_reg)
            S_CLEAR: we = 1'b1;
            S_IDLE: raddr = home_of(kin);
            S_HOME:
            begin
                if (op_reg == htcr_pkg::OP_INSERT && rd.k == '0)
                begin
                    we = 1'b1;
                    waddr = h_reg;
                    wd = new_e;
                end
            end
            S_TAIL:
            begin
                if (!rd.lv || n_reg == CW'(TABLE_SIZE))
                begin
                    we = 1'b1;
                    wd = '{k: rd.k, v: rd.v, lv: 1'b1, ln: f_reg};
                end
            end
            S_PRED:
            begin
                // The predecessor takes the moving entry's link, or else links to its new slot.
                if (rd.lv && rd.ln == h_reg)
                begin
                    we = 1'b1;
                    if (hent_reg.lv)
                    begin
                        wd = '{k: rd.k, v: rd.v, lv: 1'b1, ln: hent_reg.ln};
                    end
                    else
                    begin
                        wd = '{k: rd.k, v: rd.v, lv: 1'b1, ln: f_reg};
                    end
                end
            end
            S_WMOVE:
            begin
                we = 1'b1;
                waddr = f_reg;
                wd = '{k: hent_reg.k, v: hent_reg.v, lv: 1'b0, ln: '0};
            end
            S_WHOME:
            begin
                we = 1'b1;
                waddr = h_reg;
                wd = new_e;
            end
            S_WNEW:
            begin
                we = 1'b1;
                waddr = f_reg;
                wd = new_e;
            end
            S_ACT:
            begin
                waddr = at_reg;
                if (op_reg == htcr_pkg::OP_MODIFY)
                begin
                    we = 1'b1;
                    wd = '{k: ment_reg.k, v: val_reg, lv: ment_reg.lv, ln: ment_reg.ln};
                end
                else if (op_reg == htcr_pkg::OP_DELETE && at_reg == h_reg && !ment_reg.lv)
                begin
                    we = 1'b1;
                end
            end
            S_DNEXT:
            begin
                we = 1'b1;
                waddr = h_reg;
                wd = rd;
            end
            S_DPRED:
            begin
                if (rd.lv && rd.ln == at_reg)
                begin
                    we = 1'b1;
                    wd = '{k: rd.k, v: rd.v, lv: ment_reg.lv, ln: ment_reg.ln};
                end
            end
            S_DCLR: we = 1'b1;
            default: raddr = c_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            op_reg <= htcr_pkg::OP_INSERT;
            key_reg <= '0;
            val_reg <= '0;
            h_reg <= '0;
            f_reg <= '0;
            c_reg <= '0;
            at_reg <= '0;
            oh_reg <= '0;
            n_reg <= '0;
            hent_reg <= '0;
            ment_reg <= '0;
            st_reg <= htcr_pkg::ST_OK;
            slot_reg <= '0;
            pr_reg <= '0;
            fv_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    c_reg <= inc(c_reg);
                    if (c_reg == AW'(TABLE_SIZE - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg <= opcode;
                        key_reg <= kin;
                        val_reg <= value;
                        h_reg <= home_of(kin);
                        c_reg <= home_of(kin);
                        n_reg <= '0;
                        st_reg <= htcr_pkg::ST_OK;
                        slot_reg <= '0;
                        pr_reg <= '0;
                        fv_reg <= '0;
                        if (kin == '0)
                        begin
                            st_reg <= htcr_pkg::ST_INVALID;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_HOME;
                        end
                    end
                end
                S_HOME:
                begin
                    hent_reg <= rd;
                    oh_reg <= home_of(rd.k);
                    if (op_reg == htcr_pkg::OP_INSERT)
                    begin
                        if (rd.k == '0)
                        begin
                            slot_reg <= 6'(h_reg);
                            fv_reg <= val_reg;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            c_reg <= inc(h_reg);
                            n_reg <= CW'(1);
                            state_reg <= S_PROBER;
                        end
                    end
                    else if (rd.k == key_reg)
                    begin
                        ment_reg <= rd;
                        at_reg <= h_reg;
                        state_reg <= S_ACT;
                    end
                    else if (rd.k == '0 || home_of(rd.k) != h_reg || !rd.lv)
                    begin
                        st_reg <= htcr_pkg::ST_NOTFOUND;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        c_reg <= rd.ln;
                        n_reg <= CW'(1);
                        state_reg <= S_LOCR;
                    end
                end
                S_PROBER:
                begin
                    state_reg <= S_PROBE;
                end
                S_PROBE:
                begin
                    if (rd.k == '0)
                    begin
                        f_reg <= c_reg;
                        n_reg <= '0;
                        if (oh_reg == h_reg)
                        begin
                            c_reg <= h_reg;
                            state_reg <= S_TAILR;
                        end
                        else
                        begin
                            c_reg <= oh_reg;
                            state_reg <= S_PREDR;
                        end
                    end
                    else if (n_reg == CW'(TABLE_SIZE - 1))
                    begin
                        st_reg <= htcr_pkg::ST_FULL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        c_reg <= inc(c_reg);
                        n_reg <= n_reg + CW'(1);
                        state_reg <= S_PROBER;
                    end
                end
                S_TAILR:
                begin
                    state_reg <= S_TAIL;
                end
                S_TAIL:
                begin
                    if (rd.lv && n_reg != CW'(TABLE_SIZE))
                    begin
                        c_reg <= rd.ln;
                        n_reg <= n_reg + CW'(1);
                        state_reg <= S_TAILR;
                    end
                    else
                    begin
                        state_reg <= (oh_reg == h_reg) ? S_WNEW : S_WMOVE;
                    end
                end
                S_PREDR:
                begin
                    state_reg <= S_PRED;
                end
                S_PRED:
                begin
                    if (!rd.lv)
                    begin
                        state_reg <= S_WMOVE;
                    end
                    else if (rd.ln == h_reg)
                    begin
                        // The tail walk goes on from the predecessor's new link.
                        if (hent_reg.lv)
                        begin
                            c_reg <= hent_reg.ln;
                            n_reg <= CW'(1);
                            state_reg <= S_TAILR;
                        end
                        else
                        begin
                            state_reg <= S_WMOVE;
                        end
                    end
                    else if (n_reg == CW'(TABLE_SIZE - 1))
                    begin
                        state_reg <= S_WMOVE;
                    end
                    else
                    begin
                        c_reg <= rd.ln;
                        n_reg <= n_reg + CW'(1);
                        state_reg <= S_PREDR;
                    end
                end
                S_WMOVE:
                begin
                    state_reg <= S_WHOME;
                end
                S_WHOME:
                begin
                    slot_reg <= 6'(h_reg);
                    fv_reg <= val_reg;
                    state_reg <= S_OUT;
                end
                S_WNEW:
                begin
                    slot_reg <= 6'(f_reg);
                    fv_reg <= val_reg;
                    state_reg <= S_OUT;
                end
                S_LOCR:
                begin
                    state_reg <= S_LOC;
                end
                S_LOC:
                begin
                    if (rd.k == key_reg)
                    begin
                        ment_reg <= rd;
                        at_reg <= c_reg;
                        pr_reg <= 6'(n_reg);
                        state_reg <= S_ACT;
                    end
                    else if (!rd.lv || n_reg == CW'(TABLE_SIZE))
                    begin
                        st_reg <= htcr_pkg::ST_NOTFOUND;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        c_reg <= rd.ln;
                        n_reg <= n_reg + CW'(1);
                        state_reg <= S_LOCR;
                    end
                end
                S_ACT:
                begin
                    slot_reg <= 6'(at_reg);
                    fv_reg <= (op_reg == htcr_pkg::OP_MODIFY) ? val_reg : ment_reg.v;
                    if (op_reg != htcr_pkg::OP_DELETE)
                    begin
                        state_reg <= S_OUT;
                    end
                    else if (at_reg == h_reg)
                    begin
                        // A deleted home entry is replaced by its successor, if it has one.
                        if (ment_reg.lv)
                        begin
                            c_reg <= ment_reg.ln;
                            state_reg <= S_DNEXTR;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        c_reg <= h_reg;
                        n_reg <= '0;
                        state_reg <= S_DPREDR;
                    end
                end
                S_DNEXTR:
                begin
                    state_reg <= S_DNEXT;
                end
                S_DNEXT:
                begin
                    state_reg <= S_DCLR;
                end
                S_DPREDR:
                begin
                    state_reg <= S_DPRED;
                end
                S_DPRED:
                begin
                    if (!rd.lv || rd.ln == at_reg || n_reg == CW'(TABLE_SIZE - 1))
                    begin
                        c_reg <= at_reg;
                        state_reg <= S_DCLR;
                    end
                    else
                    begin
                        c_reg <= rd.ln;
                        n_reg <= n_reg + CW'(1);
                        state_reg <= S_DPREDR;
                    end
                end
                S_DCLR:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({status, slot, probes, found_value}));
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid));
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready);
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != htcr_pkg::ST_OK |-> slot == '0 && probes == '0
        && found_value == '0);
`endif
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for hash_table_chaining_with_replacement.
// Uses htcr_pkg for the operation and status codes; needs only the RTL.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 64;
    localparam int NO_LINK = 127;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [5:0]  probes;
        logic [31:0] found_value;
    } lookup_t;

    // Predicts each operation on its own copy of the table and holds the
    // outcomes that have not yet come back from the block.
    class table_scoreboard;
        logic [47:0] keys [SLOTS];
        logic [31:0] vals [SLOTS];
        int          links [SLOTS];
        lookup_t     pending [$];
        int          errors;

        function new();
            for (int s = 0; s < SLOTS; s++)
            begin
                keys[s] = '0;
                vals[s] = htcr_pkg::EMPTY_VALUE;
                links[s] = NO_LINK;
            end
            errors = 0;
        endfunction

        function int home(logic [47:0] k);
            int sum;
            sum = 0;
            for (int b = 0; b < 6; b++)
                sum += k[8*b +: 8];
            return sum % SLOTS;
        endfunction

        function bit linked(int s);
            return links[s] < SLOTS;
        endfunction

        function void wipe(int s);
            keys[s] = '0;
            vals[s] = htcr_pkg::EMPTY_VALUE;
            links[s] = NO_LINK;
        endfunction

        function int tail_of(int s);
            for (int n = 0; n < SLOTS && linked(s); n++)
                s = links[s];
            return s;
        endfunction

        function int pred_of(int s, int target);
            for (int n = 0; n < SLOTS; n++)
            begin
                if (!linked(s))
                    return SLOTS;
                if (links[s] == target)
                    return s;
                s = links[s];
            end
            return SLOTS;
        endfunction

        // Walks the home chain; returns the slot or -1.
        function int find(logic [47:0] k, output int hops);
            int h, c;
            h = home(k);
            c = h;
            hops = 0;
            if (keys[h] == k)
                return h;
            if (keys[h] == 0 || home(keys[h]) != h)
                return -1;
            for (int n = 1; n <= SLOTS; n++)
            begin
                if (!linked(c))
                    break;
                c = links[c];
                if (keys[c] == k)
                begin
                    hops = n;
                    return c;
                end
            end
            hops = 0;
            return -1;
        endfunction

        function void note_request(logic [1:0] op, logic [47:0] k, logic [31:0] v);
            lookup_t r;
            int h, f, oh, p, t, at, hops, c;
            bit got;
            r = '0;
            if (k == 0)
                r.status = htcr_pkg::ST_INVALID;
            else if (op == htcr_pkg::OP_INSERT)
            begin
                h = home(k);
                if (keys[h] == 0)
                begin
                    keys[h] = k;
                    vals[h] = v;
                    links[h] = NO_LINK;
                    r.slot = 6'(h);
                    r.found_value = v;
                end
                else
                begin
                    f = (h + 1) % SLOTS;
                    got = 0;
                    for (int n = 1; n < SLOTS; n++)
                    begin
                        if (keys[f] == 0)
                        begin
                            got = 1;
                            break;
                        end
                        f = (f + 1) % SLOTS;
                    end
                    if (!got)
                        r.status = htcr_pkg::ST_FULL;
                    else
                    begin
                        oh = home(keys[h]);
                        if (oh == h)
                        begin
                            t = tail_of(h);
                            keys[f] = k;
                            vals[f] = v;
                            links[f] = NO_LINK;
                            links[t] = f;
                            r.slot = 6'(f);
                        end
                        else
                        begin
                            // The squatter moves out and is relinked in its own chain.
                            p = pred_of(oh, h);
                            keys[f] = keys[h];
                            vals[f] = vals[h];
                            links[f] = NO_LINK;
                            if (p < SLOTS)
                            begin
                                links[p] = links[h];
                                t = tail_of(p);
                                links[t] = f;
                            end
                            keys[h] = k;
                            vals[h] = v;
                            links[h] = NO_LINK;
                            r.slot = 6'(h);
                        end
                        r.found_value = v;
                    end
                end
            end
            else
            begin
                at = find(k, hops);
                if (at < 0)
                    r.status = htcr_pkg::ST_NOTFOUND;
                else
                begin
                    r.slot = 6'(at);
                    r.probes = 6'(hops);
                    if (op == htcr_pkg::OP_MODIFY)
                        vals[at] = v;
                    r.found_value = vals[at];
                    if (op == htcr_pkg::OP_DELETE)
                    begin
                        h = home(k);
                        if (h == at)
                        begin
                            if (!linked(h))
                                wipe(h);
                            else
                            begin
                                c = links[h];
                                keys[h] = keys[c];
                                vals[h] = vals[c];
                                links[h] = links[c];
                                wipe(c);
                            end
                        end
                        else
                        begin
                            p = pred_of(h, at);
                            if (p < SLOTS)
                                links[p] = links[at];
                            wipe(at);
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(lookup_t got);
            lookup_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", 32'(got.status), 32'd0);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status)
                report("status", 32'(got.status), 32'(w.status));
            if (got.slot !== w.slot)
                report("slot", 32'(got.slot), 32'(w.slot));
            if (got.probes !== w.probes)
                report("probes", 32'(got.probes), 32'(w.probes));
            if (got.found_value !== w.found_value)
                report("found_value", got.found_value, w.found_value);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [47:0] key;
    logic signed [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [5:0]  probes;
    logic signed [31:0] found_value;

    table_scoreboard board;
    bit hold_off;
    logic [47:0] live_keys [$];

    hash_table_chaining_with_replacement dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .key(key), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot(slot), .probes(probes), .found_value(found_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one item and holds it until the block takes it.
    task automatic send_item(logic [1:0] op, logic [47:0] k, logic [31:0] v);
        in_valid <= 1'b1;
        opcode <= op;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(op, k, v);
        if (op == htcr_pkg::OP_INSERT && k != 0)
            live_keys.push_back(k);
    endtask

    task automatic go_idle(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Keys sharing a few home slots so that chains form and collide.
    function automatic logic [47:0] crowded_key();
        logic [47:0] k;
        k = '0;
        k[7:0] = 8'($urandom_range(1, 12));
        k[15:8] = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            k[47:16] = $urandom & 32'h0000_0303;
        return k;
    endfunction

    function automatic logic [47:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && live_keys.size() > 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if (sel < 8)
            return crowded_key();
        if (sel == 8)
            return 48'd0;
        return 48'({$urandom, $urandom});
    endfunction

    // Receiver: its own stall pattern, plus a long hold-off on request.
    initial
    begin
        int phase;
        out_ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_result(lookup_t'{status, slot, probes, found_value});
            phase++;
            if (hold_off)
                out_ready <= 1'b0;
            else if (phase % 200 < 60)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        int burst;
        logic [31:0] v;
        board = new();
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = htcr_pkg::OP_INSERT;
        key = '0;
        value = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: invalid keys, every operation, extremes, full table.
        send_item(htcr_pkg::OP_SEARCH, 48'd0, 32'd0);
        send_item(htcr_pkg::OP_INSERT, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
        send_item(htcr_pkg::OP_SEARCH, 48'hFFFF_FFFF_FFFF, 32'd0);
        send_item(htcr_pkg::OP_MODIFY, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF);
        send_item(htcr_pkg::OP_INSERT, 48'h0000_0000_0001, 32'd5);
        send_item(htcr_pkg::OP_INSERT, 48'h0000_0000_0100, 32'd6);
        send_item(htcr_pkg::OP_INSERT, 48'h0000_0000_0002, 32'd7);
        send_item(htcr_pkg::OP_INSERT, 48'h0000_0000_0041, 32'd8);
        send_item(htcr_pkg::OP_INSERT, 48'h0000_0000_0001, 32'd9);
        send_item(htcr_pkg::OP_SEARCH, 48'h0000_0000_0100, 32'd0);
        send_item(htcr_pkg::OP_SEARCH, 48'h0000_0000_0003, 32'd0);
        send_item(htcr_pkg::OP_DELETE, 48'h0000_0000_0001, 32'd0);
        send_item(htcr_pkg::OP_DELETE, 48'h0000_0000_0100, 32'd0);
        send_item(htcr_pkg::OP_DELETE, 48'hFFFF_FFFF_FFFF, 32'd0);
        send_item(htcr_pkg::OP_MODIFY, 48'h0000_0000_0009, 32'hFFFF_FFFF);
        send_item(htcr_pkg::OP_INSERT, 48'd0, 32'd1);
        for (int i = 0; i < 66; i++)
            send_item(htcr_pkg::OP_INSERT, 48'h0000_0100_0000 + i, $urandom);
        for (int i = 0; i < 66; i++)
            send_item(htcr_pkg::OP_DELETE, 48'h0000_0100_0000 + i, 32'd0);
        wait_drained();

        // The receiver holds off while items keep coming, so the input stalls.
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_item(2'($urandom_range(0, 3)), crowded_key(), $urandom);
        join
        wait_drained();

        for (int n = 0; n < 890; n += burst)
        begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst; i++)
            begin
                v = $urandom;
                if ($urandom_range(0, 15) == 0)
                    v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                send_item($urandom_range(0, 9) < 4 ? htcr_pkg::OP_INSERT
                                                   : 2'($urandom_range(0, 3)),
                          pick_key(), v);
            end
            if ($urandom_range(0, 2) != 0)
                go_idle($urandom_range(1, 30));
            if (live_keys.size() > 40)
                live_keys.delete(0);
        end

        wait_drained();
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
rtl/htcr_pkg.sv
rtl/htcr_mem.sv
rtl/hash_table_chaining_with_replacement.sv
verif/tb.sv
